/* hw/rtl/sau_pkg.sv */
// Shared types and constants for the stack arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none
package sau_pkg;

  localparam int REQ_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 10;
  localparam int OCC_W    = 11;
  localparam int STATUS_W = 3;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH      = 3'd0,
    REQ_POP       = 3'd1,
    REQ_PEEK_TOP  = 3'd2,
    REQ_PEEK_BOT  = 3'd3,
    REQ_ADD       = 3'd4,
    REQ_SUB       = 3'd5,
    REQ_MUL       = 3'd6,
    REQ_DIV       = 3'd7
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_RANGE    = 3'd3,
    ST_OPERANDS = 3'd4,
    ST_DIVZERO  = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_PEEK,
    S_RD1,
    S_RD2,
    S_ALU,
    S_MUL,
    S_ABS1,
    S_ABS2,
    S_DIV,
    S_FIX,
    S_WB,
    S_FIN
  } state_t;

endpackage
`default_nettype wire

/* hw/rtl/stack_arithmetic_unit_core.sv */
// Stack of signed words with a shared serial add/multiply/divide unit.
`timescale 1ns / 1ps
`default_nettype none
// A bounded stack of DEPTH words of DATA_WIDTH bits in a single-port-write,
// registered-read memory, driven by a small sequencer around one shared
// adder. One request is worked at a time; in_stall is high from the beat
// after acceptance until the sequencer returns to idle, and a finished
// result waits in the output register while the next request is taken.
// A request that fails its check goes from decode straight to the result
// state, and a zero divisor does so once both operands are read. The next
// request is taken in the idle state entered as the result is loaded, and
// a stalled output register holds the sequencer in its last state.
// Multiply and divide run one-bit-per-cycle shift-add and restoring-divide
// loops through the shared adder. Memory entries are undefined until
// pushed; no clearing pass.
module stack_arithmetic_unit_core #(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic [sau_pkg::REQ_W-1:0]              in_req_type,
  input  wire logic signed [sau_pkg::VALUE_W-1:0]     in_push_value,
  input  wire logic [sau_pkg::POS_W-1:0]              in_position,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic signed [sau_pkg::VALUE_W-1:0]          out_value,
  output logic [sau_pkg::OCC_W-1:0]                   out_occupancy,
  output logic [sau_pkg::STATUS_W-1:0]                out_status
);

  localparam int W    = DATA_WIDTH;
  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > sau_pkg::POS_W) ? CW : sau_pkg::POS_W;
  localparam int ITW  = $clog2(DATA_WIDTH);

  sau_pkg::state_t  state_r, state_nxt;
  sau_pkg::req_t    req_r;
  logic [W-1:0]     pv_r;
  logic [sau_pkg::POS_W-1:0] pos_r;

  logic [CW-1:0]    count_r, count_nxt;
  logic [W-1:0]     a_r, a_nxt;
  logic [W-1:0]     b_r, b_nxt;
  logic [W-1:0]     acc_r, acc_nxt;
  logic [W-1:0]     q_r, q_nxt;
  logic [ITW-1:0]   it_r, it_nxt;
  logic             qneg_r, qneg_nxt;
  logic [W-1:0]     val_r, val_nxt;
  sau_pkg::status_t st_r, st_nxt;

  logic             out_valid_r;
  logic [sau_pkg::VALUE_W-1:0] out_value_r;
  logic [sau_pkg::OCC_W-1:0]   out_occupancy_r;
  sau_pkg::status_t            out_status_r;

  // memory
  logic [W-1:0]     mem [DEPTH];
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [W-1:0]     mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [W-1:0]     rdata_r;

  // shared adder
  logic [W:0]       add_x, add_y;
  logic             add_inv, add_cin;
  logic [W+1:0]     add_sum;

  logic [CW-1:0]    cnt_m1, cnt_m2;
  logic [CMPW-1:0]  pos_ext, count_ext, top_idx;
  logic             pos_bad, is_full, out_free;

  assign add_sum = {1'b0, add_x} + {1'b0, add_y ^ {(W+1){add_inv}}} + {{(W+1){1'b0}}, add_cin};

  assign cnt_m1    = count_r - CW'(1);
  assign cnt_m2    = count_r - CW'(2);
  assign pos_ext   = CMPW'(pos_r);
  assign count_ext = CMPW'(count_r);
  assign top_idx   = count_ext - pos_ext - CMPW'(1);
  assign pos_bad   = (pos_ext >= count_ext);
  assign is_full   = (count_r == CW'(DEPTH));
  assign out_free  = !out_valid_r || !out_stall;

  assign in_stall      = (state_r != sau_pkg::S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_occupancy = out_occupancy_r;
  assign out_status    = out_status_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[mem_raddr];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sau_pkg::S_IDLE:   if (in_valid) state_nxt = sau_pkg::S_DECODE;
      sau_pkg::S_DECODE: begin
        unique case (req_r)
          sau_pkg::REQ_PUSH: state_nxt = sau_pkg::S_FIN;
          sau_pkg::REQ_POP:
            state_nxt = (count_r == '0) ? sau_pkg::S_FIN : sau_pkg::S_PEEK;
          sau_pkg::REQ_PEEK_TOP, sau_pkg::REQ_PEEK_BOT:
            state_nxt = pos_bad ? sau_pkg::S_FIN : sau_pkg::S_PEEK;
          default:
            state_nxt = (count_r < CW'(2)) ? sau_pkg::S_FIN : sau_pkg::S_RD1;
        endcase
      end
      sau_pkg::S_PEEK:   state_nxt = sau_pkg::S_FIN;
      sau_pkg::S_RD1:    state_nxt = sau_pkg::S_RD2;
      sau_pkg::S_RD2: begin
        unique case (req_r)
          sau_pkg::REQ_MUL: state_nxt = sau_pkg::S_MUL;
          sau_pkg::REQ_DIV:
            state_nxt = (a_r == '0) ? sau_pkg::S_FIN : sau_pkg::S_ABS1;
          default:          state_nxt = sau_pkg::S_ALU;
        endcase
      end
      sau_pkg::S_ALU:    state_nxt = sau_pkg::S_WB;
      sau_pkg::S_MUL:    if (it_r == '0) state_nxt = sau_pkg::S_WB;
      sau_pkg::S_ABS1:   state_nxt = sau_pkg::S_ABS2;
      sau_pkg::S_ABS2:   state_nxt = sau_pkg::S_DIV;
      sau_pkg::S_DIV:    if (it_r == '0) state_nxt = sau_pkg::S_FIX;
      sau_pkg::S_FIX:    state_nxt = sau_pkg::S_WB;
      sau_pkg::S_WB:     state_nxt = sau_pkg::S_FIN;
      sau_pkg::S_FIN:    if (out_free) state_nxt = sau_pkg::S_IDLE;
      default:           state_nxt = sau_pkg::S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    count_nxt = count_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    acc_nxt   = acc_r;
    q_nxt     = q_r;
    it_nxt    = it_r;
    qneg_nxt  = qneg_r;
    val_nxt   = val_r;
    st_nxt    = st_r;
    mem_we    = 1'b0;
    mem_waddr = count_r[AW-1:0];
    mem_wdata = acc_r;
    mem_raddr = cnt_m1[AW-1:0];
    add_x     = {1'b0, acc_r};
    add_y     = {1'b0, a_r};
    add_inv   = 1'b0;
    add_cin   = 1'b0;
    unique case (state_r)
      sau_pkg::S_DECODE: begin
        val_nxt = '0;
        st_nxt  = sau_pkg::ST_OK;
        unique case (req_r)
          sau_pkg::REQ_PUSH: begin
            if (is_full) begin
              st_nxt = sau_pkg::ST_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_wdata = pv_r;
              count_nxt = count_r + CW'(1);
            end
          end
          sau_pkg::REQ_POP: begin
            if (count_r == '0) begin
              st_nxt = sau_pkg::ST_EMPTY;
            end else begin
              count_nxt = cnt_m1;
            end
          end
          sau_pkg::REQ_PEEK_TOP: begin
            mem_raddr = top_idx[AW-1:0];
            if (pos_bad) st_nxt = sau_pkg::ST_RANGE;
          end
          sau_pkg::REQ_PEEK_BOT: begin
            mem_raddr = pos_ext[AW-1:0];
            if (pos_bad) st_nxt = sau_pkg::ST_RANGE;
          end
          default: begin
            if (count_r < CW'(2)) st_nxt = sau_pkg::ST_OPERANDS;
          end
        endcase
      end
      sau_pkg::S_PEEK: val_nxt = rdata_r;
      sau_pkg::S_RD1: begin
        a_nxt     = rdata_r;
        mem_raddr = cnt_m2[AW-1:0];
      end
      sau_pkg::S_RD2: begin
        // both operands consumed, even on a zero divisor
        b_nxt     = rdata_r;
        q_nxt     = rdata_r;
        acc_nxt   = '0;
        it_nxt    = ITW'(W - 1);
        qneg_nxt  = a_r[W-1] ^ rdata_r[W-1];
        count_nxt = cnt_m2;
        if (req_r == sau_pkg::REQ_DIV && a_r == '0) st_nxt = sau_pkg::ST_DIVZERO;
      end
      sau_pkg::S_ALU: begin
        add_x   = {1'b0, b_r};
        add_y   = {1'b0, a_r};
        add_inv = (req_r == sau_pkg::REQ_SUB);
        add_cin = (req_r == sau_pkg::REQ_SUB);
        acc_nxt = add_sum[W-1:0];
      end
      sau_pkg::S_MUL: begin
        // shift-add: one multiplier bit per cycle
        add_x = {1'b0, acc_r};
        add_y = {1'b0, a_r};
        if (q_r[0]) acc_nxt = add_sum[W-1:0];
        a_nxt  = {a_r[W-2:0], 1'b0};
        q_nxt  = {1'b0, q_r[W-1:1]};
        it_nxt = it_r - ITW'(1);
      end
      sau_pkg::S_ABS1: begin
        add_x   = '0;
        add_y   = {1'b0, a_r};
        add_inv = 1'b1;
        add_cin = 1'b1;
        if (a_r[W-1]) a_nxt = add_sum[W-1:0];
      end
      sau_pkg::S_ABS2: begin
        add_x   = '0;
        add_y   = {1'b0, b_r};
        add_inv = 1'b1;
        add_cin = 1'b1;
        if (b_r[W-1]) q_nxt = add_sum[W-1:0];
      end
      sau_pkg::S_DIV: begin
        // restoring step: trial subtract of divisor from shifted remainder
        add_x   = {acc_r, q_r[W-1]};
        add_y   = {1'b0, a_r};
        add_inv = 1'b1;
        add_cin = 1'b1;
        if (add_sum[W+1]) begin
          acc_nxt = add_sum[W-1:0];
          q_nxt   = {q_r[W-2:0], 1'b1};
        end else begin
          acc_nxt = {acc_r[W-2:0], q_r[W-1]};
          q_nxt   = {q_r[W-2:0], 1'b0};
        end
        it_nxt = it_r - ITW'(1);
      end
      sau_pkg::S_FIX: begin
        // floor: negate a negative quotient, and round down when a remainder is left
        add_x   = '0;
        add_y   = {1'b0, q_r};
        add_inv = 1'b1;
        add_cin = (acc_r == '0);
        acc_nxt = qneg_r ? add_sum[W-1:0] : q_r;
      end
      sau_pkg::S_WB: begin
        mem_we    = 1'b1;
        mem_wdata = acc_r;
        count_nxt = count_r + CW'(1);
        val_nxt   = acc_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sau_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (state_r == sau_pkg::S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == sau_pkg::S_IDLE && in_valid) begin
      req_r <= sau_pkg::req_t'(in_req_type);
      pv_r  <= W'(in_push_value);
      pos_r <= in_position;
    end
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    acc_r  <= acc_nxt;
    q_r    <= q_nxt;
    it_r   <= it_nxt;
    qneg_r <= qneg_nxt;
    val_r  <= val_nxt;
    st_r   <= st_nxt;
    if (state_r == sau_pkg::S_FIN && out_free) begin
      out_value_r     <= sau_pkg::VALUE_W'($signed(val_r));
      out_occupancy_r <= sau_pkg::OCC_W'(count_r);
      out_status_r    <= st_r;
    end
  end

endmodule
`default_nettype wire
